// ===== rtl/core/mrtf_pkg.sv =====
// Shared types and constants of the meter reading text formatter.
package mrtf_pkg;

    // Text geometry: ten characters per reading.
    localparam int unsigned TextLen = 10;
    localparam int unsigned PosW    = $clog2(TextLen);
    localparam int unsigned CharW   = 8;

    // Scaling factors and the saturation limit of the scaled value.
    localparam logic [13:0] FactorVolt  = 14'd100;
    localparam logic [13:0] FactorMilli = 14'd10000;
    localparam logic [15:0] BcdMax      = 16'h9999;

    // Number of radix-4 division steps for a 14-bit quotient.
    localparam int unsigned DivSteps = 7;
    localparam int unsigned StepW    = $clog2(DivSteps);

    // Queue between the front and back parts.
    localparam int unsigned QueueDepth = 2;
    localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
    localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

    // Register map and reset values.
    localparam logic REG_VOLT_DIV = 1'b0;
    localparam logic REG_AMP_DIV  = 1'b1;
    localparam logic [15:0] VoltDivReset = 16'd1969;
    localparam logic [15:0] AmpDivReset  = 16'd11636;

    // ASCII characters used in the text.
    localparam logic [7:0] CH_U     = 8'h55;
    localparam logic [7:0] CH_I     = 8'h49;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_M     = 8'h6D;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_V     = 8'h56;

    // Text layout of one reading.
    typedef enum logic [1:0] {
        LAYOUT_VOLT,
        LAYOUT_AMP,
        LAYOUT_MILLI
    } layout_t;

    // One formatted reading: layout and four BCD digits, thousands on top.
    typedef struct packed {
        layout_t     layout;
        logic [15:0] bcd;
    } text_rec_t;

    // Handoff from the front part into the queue.
    typedef struct packed {
        logic      valid;
        text_rec_t rec;
    } rec_push_t;

endpackage

// ===== rtl/core/mrtf_front.sv =====
// Front part: takes readings, picks the layout and computes the scaled BCD value.
module mrtf_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [15:0]         s_tdata,   // [15:0] reading
    input  logic                s_tuser,   // [0] is_current
    input  logic [15:0]         volt_divisor,
    input  logic [15:0]         amp_divisor,
    output mrtf_pkg::rec_push_t push,
    input  logic                q_full
);

    typedef enum logic [1:0] {
        E_IDLE,
        E_MUL,
        E_DIV,
        E_OUT
    } eng_state_t;

    eng_state_t                   state_reg;
    logic [mrtf_pkg::StepW-1:0]   step_reg;

    logic                         in_valid_reg;
    logic [15:0]                  in_reading_reg;
    logic                         in_current_reg;

    mrtf_pkg::layout_t            layout_reg;
    logic [15:0]                  reading_reg;
    logic [15:0]                  div_reg;
    logic [29:0]                  n_reg;
    logic [29:0]                  d10k_reg;
    logic [16:0]                  d2_reg;
    logic [17:0]                  d3_reg;
    logic [15:0]                  rem_reg;
    logic [13:0]                  low_reg;
    logic [15:0]                  bcd_reg;

    logic                         take;
    logic                         in_milli;
    logic [13:0]                  factor;
    logic [29:0]                  prod;
    logic [29:0]                  d10k;
    logic [17:0]                  r4;
    logic [1:0]                   qdig;
    logic [15:0]                  rem_next;
    logic                         sat;

    // Shift one quotient bit into a four-digit BCD accumulator.
    function automatic logic [15:0] dabble(input logic [15:0] b, input logic bit_in);
        logic [15:0] a;
        a = b;
        for (int i = 0; i < 4; i++)
        begin
            if (a[4*i +: 4] >= 4'd5)
            begin
                a[4*i +: 4] = a[4*i +: 4] + 4'd3;
            end
        end
        return {a[14:0], bit_in};
    endfunction

    // The engine takes the waiting item when it is idle or hands off its result.
    assign take = in_valid_reg && ((state_reg == E_IDLE) || ((state_reg == E_OUT) && !q_full));
    assign s_tready = !in_valid_reg || take;

    // Input stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_reading_reg <= s_tdata;
            in_current_reg <= s_tuser;
        end
    end

    // A current below one ampere takes the milliampere layout.
    assign in_milli = in_current_reg && (in_reading_reg < amp_divisor);

    // Multiply stage operands.
    assign factor = (layout_reg == mrtf_pkg::LAYOUT_MILLI) ? mrtf_pkg::FactorMilli
                                                           : mrtf_pkg::FactorVolt;
    assign prod = 30'(reading_reg) * 30'(factor);
    assign d10k = 30'(div_reg) * 30'(mrtf_pkg::FactorMilli);

    // Radix-4 division step: compare against d, 2d and 3d in parallel.
    assign r4 = {rem_reg, low_reg[13:12]};
    always_comb
    begin
        if (r4 >= d3_reg)
        begin
            qdig     = 2'd3;
            rem_next = 16'(r4 - d3_reg);
        end
        else if (r4 >= 18'(d2_reg))
        begin
            qdig     = 2'd2;
            rem_next = 16'(r4 - 18'(d2_reg));
        end
        else if (r4 >= 18'(div_reg))
        begin
            qdig     = 2'd1;
            rem_next = 16'(r4 - 18'(div_reg));
        end
        else
        begin
            qdig     = 2'd0;
            rem_next = r4[15:0];
        end
    end

    // Engine control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= E_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            case (state_reg)
                E_IDLE:
                begin
                    if (take)
                    begin
                        state_reg <= E_MUL;
                    end
                end
                E_MUL:
                begin
                    state_reg <= E_DIV;
                    step_reg  <= '0;
                end
                E_DIV:
                begin
                    if (step_reg == mrtf_pkg::StepW'(mrtf_pkg::DivSteps - 1))
                    begin
                        state_reg <= E_OUT;
                    end
                    else
                    begin
                        step_reg <= step_reg + 1'b1;
                    end
                end
                E_OUT:
                begin
                    if (!q_full)
                    begin
                        state_reg <= take ? E_MUL : E_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= E_IDLE;
                end
            endcase
        end
    end

    // Engine datapath.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            reading_reg <= in_reading_reg;
            div_reg     <= in_current_reg ? amp_divisor : volt_divisor;
            if (in_milli)
            begin
                layout_reg <= mrtf_pkg::LAYOUT_MILLI;
            end
            else if (in_current_reg)
            begin
                layout_reg <= mrtf_pkg::LAYOUT_AMP;
            end
            else
            begin
                layout_reg <= mrtf_pkg::LAYOUT_VOLT;
            end
        end
        if (state_reg == E_MUL)
        begin
            n_reg    <= prod;
            d10k_reg <= d10k;
            d2_reg   <= {div_reg, 1'b0};
            d3_reg   <= 18'(div_reg) + 18'({div_reg, 1'b0});
            rem_reg  <= prod[29:14];
            low_reg  <= prod[13:0];
            bcd_reg  <= '0;
        end
        if (state_reg == E_DIV)
        begin
            rem_reg <= rem_next;
            low_reg <= {low_reg[11:0], 2'b00};
            bcd_reg <= dabble(dabble(bcd_reg, qdig[1]), qdig[0]);
        end
    end

    // A zero divisor or a quotient above 9999 shows 9999.
    assign sat = (div_reg == 16'd0) || (n_reg >= d10k_reg);

    assign push.valid      = (state_reg == E_OUT);
    assign push.rec.layout = layout_reg;
    assign push.rec.bcd    = sat ? mrtf_pkg::BcdMax : bcd_reg;

endmodule

// ===== rtl/core/mrtf_queue.sv =====
// Two-entry queue of formatted readings between the front and back parts.
module mrtf_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  mrtf_pkg::rec_push_t push,
    output logic                full,
    input  logic                pop,
    output logic                q_valid,
    output mrtf_pkg::text_rec_t q_rec
);

    mrtf_pkg::text_rec_t                entry_reg [mrtf_pkg::QueueDepth];
    logic [mrtf_pkg::QueuePtrW-1:0]     wr_ptr_reg;
    logic [mrtf_pkg::QueuePtrW-1:0]     rd_ptr_reg;
    logic [mrtf_pkg::QueueCntW-1:0]     count_reg;
    logic                               do_push;
    logic                               do_pop;

    assign full    = (count_reg == mrtf_pkg::QueueCntW'(mrtf_pkg::QueueDepth));
    assign q_valid = (count_reg != '0);
    assign q_rec   = entry_reg[rd_ptr_reg];
    assign do_push = push.valid && !full;
    assign do_pop  = pop && q_valid;

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push.rec;
        end
    end

endmodule

// ===== rtl/core/mrtf_back.sv =====
// Back part: sends the ten characters of each formatted reading through an output register.
module mrtf_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  mrtf_pkg::text_rec_t q_rec,
    output logic                q_pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [7:0]          m_tdata,   // [7:0] text_char
    output logic                m_tlast    // final_char
);

    logic                           cur_valid_reg;
    mrtf_pkg::text_rec_t            cur_rec_reg;
    logic [mrtf_pkg::PosW-1:0]      pos_reg;
    logic                           m_tvalid_reg;
    logic [7:0]                     m_tdata_reg;
    logic                           m_tlast_reg;

    logic                           out_free;
    logic                           issue;
    logic                           last;
    logic [7:0]                     cur_char;

    // ASCII of one BCD digit.
    function automatic logic [7:0] ascii(input logic [3:0] d);
        return {4'h3, d};
    endfunction

    // Character at one position of the text.
    function automatic logic [7:0] char_at(input mrtf_pkg::text_rec_t r,
                                           input logic [mrtf_pkg::PosW-1:0] p);
        logic [3:0] d3;
        logic [3:0] d2;
        logic [3:0] d1;
        logic [3:0] d0;
        logic       milli;
        logic       amp;
        logic [7:0] c;
        d3    = r.bcd[15:12];
        d2    = r.bcd[11:8];
        d1    = r.bcd[7:4];
        d0    = r.bcd[3:0];
        milli = (r.layout == mrtf_pkg::LAYOUT_MILLI);
        amp   = (r.layout == mrtf_pkg::LAYOUT_AMP);
        case (p)
            4'd0:    c = (milli || amp) ? mrtf_pkg::CH_I : mrtf_pkg::CH_U;
            4'd1:    c = mrtf_pkg::CH_EQ;
            4'd2:    c = (milli && (d3 != 4'd0)) ? ascii(d3) : mrtf_pkg::CH_SPACE;
            4'd3:
            begin
                if (milli)
                begin
                    c = ((d3 != 4'd0) || (d2 != 4'd0)) ? ascii(d2) : mrtf_pkg::CH_SPACE;
                end
                else
                begin
                    c = (d3 != 4'd0) ? ascii(d3) : mrtf_pkg::CH_SPACE;
                end
            end
            4'd4:    c = milli ? ascii(d1) : ascii(d2);
            4'd5:    c = mrtf_pkg::CH_DOT;
            4'd6:    c = milli ? ascii(d0) : ascii(d1);
            4'd7:    c = milli ? mrtf_pkg::CH_ZERO : ascii(d0);
            4'd8:    c = milli ? mrtf_pkg::CH_M : mrtf_pkg::CH_SPACE;
            4'd9:    c = (milli || amp) ? mrtf_pkg::CH_A : mrtf_pkg::CH_V;
            default: c = mrtf_pkg::CH_SPACE;
        endcase
        return c;
    endfunction

    // A character moves into the output register whenever that register is free.
    assign out_free = !m_tvalid_reg || m_tready;
    assign issue    = cur_valid_reg && out_free;
    assign last     = (pos_reg == mrtf_pkg::PosW'(mrtf_pkg::TextLen - 1));
    assign q_pop    = q_valid && (!cur_valid_reg || (issue && last));
    assign cur_char = char_at(cur_rec_reg, pos_reg);

    // Sequencer and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            pos_reg       <= '0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                cur_valid_reg <= 1'b1;
                pos_reg       <= '0;
            end
            else if (issue)
            begin
                if (last)
                begin
                    cur_valid_reg <= 1'b0;
                end
                pos_reg <= pos_reg + 1'b1;
            end
            if (out_free)
            begin
                m_tvalid_reg <= issue;
            end
        end
    end

    // Current reading and output character.
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_rec_reg <= q_rec;
        end
        if (issue)
        begin
            m_tdata_reg <= cur_char;
            m_tlast_reg <= last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

// ===== rtl/core/meter_reading_text_formatter.sv =====
// Top level of the meter reading text formatter: register port, front, queue and back.
//
// Each accepted reading (s_tdata, with s_tuser set for a current) turns into ten ASCII
// characters on the output, position 0 first, with m_tlast on the tenth. Characters leave
// at one per cycle while m_tready is high, a rate set by the character output of the back
// part. The front part works through a multiply state, seven radix-4 division steps that
// build the BCD digits directly and a handoff state, and runs ahead through a two-entry
// queue, so both sides stall on their own. A reading passes the input register, the
// engine, the queue and the output register before its first character appears.
// volt_divisor sits at address 0 and amp_divisor at address 4; the user is to see that both
// are written only while the block is idle, which the block itself does not enforce.
module meter_reading_text_formatter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] reading
    input  logic        s_tuser,   // [0] is_current
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] text_char
    output logic        m_tlast    // final_char
);

    logic [15:0]         volt_div_reg;
    logic [15:0]         amp_div_reg;
    logic                cfg_write;

    mrtf_pkg::rec_push_t push;
    logic                q_full;
    logic                q_pop;
    logic                q_valid;
    mrtf_pkg::text_rec_t q_rec;

    // Configuration registers.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            volt_div_reg <= mrtf_pkg::VoltDivReset;
            amp_div_reg  <= mrtf_pkg::AmpDivReset;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == mrtf_pkg::REG_AMP_DIV)
            begin
                amp_div_reg <= pwdata[15:0];
            end
            else
            begin
                volt_div_reg <= pwdata[15:0];
            end
        end
    end

    assign prdata = {16'h0000, (paddr[2] == mrtf_pkg::REG_AMP_DIV) ? amp_div_reg : volt_div_reg};

    mrtf_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .volt_divisor (volt_div_reg),
        .amp_divisor  (amp_div_reg),
        .push         (push),
        .q_full       (q_full)
    );

    mrtf_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (q_full),
        .pop     (q_pop),
        .q_valid (q_valid),
        .q_rec   (q_rec)
    );

    mrtf_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_rec    (q_rec),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // The last character of every text is the unit letter.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> (m_tdata == mrtf_pkg::CH_A) || (m_tdata == mrtf_pkg::CH_V))
        else $error("final character is not a unit letter");

    // A result handed to a queue with room is waiting there in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        push.valid && !q_full |=> q_valid)
        else $error("queue lost a handed-off reading");

    // The queue never reports full while it is empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> q_valid)
        else $error("queue full and empty at once");

endmodule

// ===== dv/meter_reading_text_formatter_test.sv =====
// Self-checking testbench of the meter reading text formatter: stream stimulus, text prediction.
`timescale 1ns / 1ps

module meter_reading_text_formatter_test;

    // Register byte addresses on the configuration port.
    localparam logic [2:0] ADDR_VOLT_DIV = {mrtf_pkg::REG_VOLT_DIV, 2'b00};
    localparam logic [2:0] ADDR_AMP_DIV  = {mrtf_pkg::REG_AMP_DIV, 2'b00};

    // Scaling of the displayed value.
    localparam int unsigned SCALE_HUNDREDTHS = 100;
    localparam int unsigned SCALE_TENTH_MA   = 10000;
    localparam int unsigned VALUE_LIMIT      = 9999;

    localparam int CLK_PERIOD     = 8;
    localparam int RESET_CYCLES   = 8;
    localparam int SETTLE_CYCLES  = 24;
    localparam int HOLD_CYCLES    = 300;
    localparam int RANDOM_PHASES  = 5;
    localparam int PHASE_ITEMS    = 22;
    localparam int REPORT_LIMIT   = 10;
    localparam int TIMEOUT_CYCLES = 400000;

    typedef struct {
        logic [15:0] reading;
        logic        is_current;
    } reading_item_t;

    typedef struct {
        logic [7:0] ch;
        logic       last;
    } text_char_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;    // [15:0] reading
    logic        s_tuser = 1'b0;  // [0] is_current
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;         // [7:0] text_char
    logic        m_tlast;         // final_char

    // Readings waiting to be sent and characters still due from the block.
    reading_item_t pending_readings[$];
    text_char_t    expected_text[$];

    // Divisors as the block should hold them.
    logic [15:0] volt_divisor = mrtf_pkg::VoltDivReset;
    logic [15:0] amp_divisor  = mrtf_pkg::AmpDivReset;

    int  mismatch_count = 0;
    int  cycle_count = 0;
    logic input_taken = 1'b0;
    bit  steady_flow = 1'b0;
    int  send_gap = 0;
    int  stall_left = 0;
    int  hold_left = 0;
    int  hold_requests = 0;
    int  hold_served = 0;

    meter_reading_text_formatter dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Scaled value of a reading, saturated at the largest four-digit value.
    function automatic int unsigned scaled_value(input logic [15:0] reading,
                                                 input int unsigned factor,
                                                 input logic [15:0] divisor);
        longint unsigned v;
        if (divisor == 16'd0)
            return VALUE_LIMIT;
        v = 64'(reading);
        v = (v * factor) / divisor;
        return (v > VALUE_LIMIT) ? VALUE_LIMIT : 32'(v);
    endfunction

    function automatic logic [7:0] digit_char(input int unsigned value, input int unsigned place);
        return mrtf_pkg::CH_ZERO + 8'((value / place) % 10);
    endfunction

    // Works out the ten characters of one reading and queues them.
    function automatic void predict_text(input logic [15:0] reading, input logic is_current);
        logic [7:0]  text [mrtf_pkg::TextLen];
        int unsigned v;
        text_char_t  c;
        if (is_current && reading < amp_divisor)
        begin
            // Milliampere layout with tenths of a milliampere.
            v = scaled_value(reading, SCALE_TENTH_MA, amp_divisor);
            text[0] = mrtf_pkg::CH_I;
            text[1] = mrtf_pkg::CH_EQ;
            text[2] = (v >= 1000) ? digit_char(v, 1000) : mrtf_pkg::CH_SPACE;
            text[3] = (v >= 100) ? digit_char(v, 100) : mrtf_pkg::CH_SPACE;
            text[4] = digit_char(v, 10);
            text[5] = mrtf_pkg::CH_DOT;
            text[6] = digit_char(v, 1);
            text[7] = mrtf_pkg::CH_ZERO;
            text[8] = mrtf_pkg::CH_M;
            text[9] = mrtf_pkg::CH_A;
        end
        else
        begin
            // Volt or ampere layout with hundredths.
            v = scaled_value(reading, SCALE_HUNDREDTHS, is_current ? amp_divisor : volt_divisor);
            text[0] = is_current ? mrtf_pkg::CH_I : mrtf_pkg::CH_U;
            text[1] = mrtf_pkg::CH_EQ;
            text[2] = mrtf_pkg::CH_SPACE;
            text[3] = (v >= 1000) ? digit_char(v, 1000) : mrtf_pkg::CH_SPACE;
            text[4] = digit_char(v, 100);
            text[5] = mrtf_pkg::CH_DOT;
            text[6] = digit_char(v, 10);
            text[7] = digit_char(v, 1);
            text[8] = mrtf_pkg::CH_SPACE;
            text[9] = is_current ? mrtf_pkg::CH_A : mrtf_pkg::CH_V;
        end
        for (int k = 0; k < mrtf_pkg::TextLen; k++)
        begin
            c.ch = text[k];
            c.last = (k == mrtf_pkg::TextLen - 1);
            expected_text.push_back(c);
        end
    endfunction

    // Idle stretch: mostly short, sometimes long.
    function automatic int idle_length();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Random reading that often lands near the layout and saturation boundaries.
    function automatic logic [15:0] pick_reading(input logic is_current);
        int div;
        int r;
        div = int'(is_current ? amp_divisor : volt_divisor);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: r = $urandom_range(0, 65535);
            4, 5: r = (div == 0) ? $urandom_range(0, 65535) : $urandom_range(0, div - 1);
            6, 7: r = div + $urandom_range(0, 6) - 3;
            8: r = $urandom_range(0, 60);
            default: r = $urandom_range(0, 1) ? 65535 : 0;
        endcase
        if (r < 0)
            r = 0;
        if (r > 65535)
            r = 65535;
        return 16'(r);
    endfunction

    function automatic void queue_reading(input logic [15:0] reading, input logic is_current);
        reading_item_t item;
        item.reading = reading;
        item.is_current = is_current;
        pending_readings.push_back(item);
    endfunction

    // One register write: setup cycle, then access cycle. Upper data bits are noise.
    task automatic write_register(input logic [2:0] addr, input logic [15:0] value);
        logic [15:0] upper;
        upper = 16'($urandom);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= {upper, value};
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_divisors(input logic [15:0] volt_value, input logic [15:0] amp_value);
        write_register(ADDR_VOLT_DIV, volt_value);
        volt_divisor = volt_value;
        write_register(ADDR_AMP_DIV, amp_value);
        amp_divisor = amp_value;
    endtask

    // Waits until every item is sent and every character is in, then lets the block settle.
    task automatic wait_idle();
        while (pending_readings.size() != 0 || s_tvalid || expected_text.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Sender: offers the pending items, with random gaps unless the flow is steady.
    always @(negedge clk)
    begin : sender
        reading_item_t item;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else if (s_tvalid && !input_taken)
        begin
            // The offered item waits for the block.
        end
        else if (send_gap > 0)
        begin
            send_gap--;
            s_tvalid <= 1'b0;
        end
        else if (pending_readings.size() != 0)
        begin
            item = pending_readings.pop_front();
            s_tvalid <= 1'b1;
            s_tdata <= item.reading;
            s_tuser <= item.is_current;
            send_gap = (!steady_flow && $urandom_range(0, 99) < 30) ? idle_length() : 0;
        end
        else
        begin
            s_tvalid <= 1'b0;
        end
    end

    // Receiver: random stalls, plus a long hold-off whenever one is requested.
    always @(negedge clk)
    begin : receiver
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else if (hold_served != hold_requests)
        begin
            hold_served++;
            hold_left = HOLD_CYCLES - 1;
            m_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
            if (!steady_flow && $urandom_range(0, 99) < 25)
                stall_left = idle_length();
        end
    end

    // Monitor: compares each character with the oldest expected one and predicts new items.
    always @(posedge clk)
    begin : monitor
        text_char_t due;
        cycle_count++;
        if (cycle_count > TIMEOUT_CYCLES)
        begin
            $display("Timeout after %0d cycles, %0d characters still due",
                     cycle_count, expected_text.size());
            $display("RESULT: ERROR");
            $finish;
        end
        else if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_text.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("Unexpected character %h last %b", m_tdata, m_tlast);
                end
                else
                begin
                    due = expected_text.pop_front();
                    if (m_tdata !== due.ch || m_tlast !== due.last)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT)
                            $display("Character mismatch: expected %h last %b, got %h last %b",
                                     due.ch, due.last, m_tdata, m_tlast);
                    end
                end
            end
            if (s_tvalid && s_tready)
                predict_text(s_tdata, s_tuser);
            input_taken <= s_tvalid && s_tready;
        end
    end

    // Stimulus: directed cases under fixed divisors, then random phases.
    initial
    begin
        logic is_current;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset divisors: zero, layout boundaries and the milliampere blanking cases.
        queue_reading(16'd0, 1'b0);
        queue_reading(16'd65535, 1'b0);
        queue_reading(16'd1969, 1'b0);
        queue_reading(16'd0, 1'b1);
        queue_reading(16'd100, 1'b1);
        queue_reading(16'd1163, 1'b1);
        queue_reading(16'd1164, 1'b1);
        queue_reading(16'd11635, 1'b1);
        queue_reading(16'd11636, 1'b1);
        queue_reading(16'd65535, 1'b1);
        wait_idle();

        // Smallest volt divisor saturates; largest amp divisor puts 65534 in milliamperes, 65535 in amperes.
        set_divisors(16'd1, 16'd65535);
        queue_reading(16'd65535, 1'b0);
        queue_reading(16'd9, 1'b0);
        queue_reading(16'd65534, 1'b1);
        queue_reading(16'd65535, 1'b1);
        wait_idle();

        // Largest volt divisor, smallest amp divisor.
        set_divisors(16'd65535, 16'd1);
        queue_reading(16'd1, 1'b0);
        queue_reading(16'd65535, 1'b0);
        queue_reading(16'd0, 1'b1);
        queue_reading(16'd65535, 1'b1);
        wait_idle();

        // Zero divisors: saturated value, and currents always in the ampere layout.
        set_divisors(16'd0, 16'd0);
        queue_reading(16'd0, 1'b0);
        queue_reading(16'd65535, 1'b0);
        queue_reading(16'd0, 1'b1);
        queue_reading(16'd4660, 1'b1);
        wait_idle();

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0: set_divisors(mrtf_pkg::VoltDivReset, mrtf_pkg::AmpDivReset);
                1: set_divisors(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)));
                2: set_divisors(16'($urandom_range(1, 300)), 16'($urandom_range(1, 300)));
                3: set_divisors(16'($urandom_range(40000, 65535)),
                                16'($urandom_range(40000, 65535)));
                default: set_divisors(16'($urandom_range(500, 20000)),
                                      16'($urandom_range(500, 20000)));
            endcase
            @(posedge clk);
            steady_flow = (phase == 2);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                is_current = 1'($urandom_range(0, 1));
                queue_reading(pick_reading(is_current), is_current);
            end
            if (phase == 2)
            begin
                // Hold the output back while the sender keeps offering items.
                do
                    @(posedge clk);
                while (!(s_tvalid && s_tready));
                hold_requests++;
            end
            wait_idle();
            @(posedge clk);
            steady_flow = 1'b0;
        end

        wait_idle();
        if (mismatch_count == 0 && expected_text.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
